@@ src/yuv2rgb_pkg.sv @@
// Package for the YUV 4:2:0 to RGB rotating converter.
// Holds payload structs, register indexes, field widths and Q16 coefficients.
// No dependencies.
package yuv2rgb_pkg;

  // Geometry
  localparam int unsigned MaxDim  = 2048;
  localparam int unsigned DimW    = 12;               // width of a dimension register
  localparam int unsigned CntW    = $clog2(MaxDim);   // column and row counters
  localparam int unsigned OffsetW = 24;
  localparam int unsigned Drp3W   = DimW + 2;         // 3 * dest_row_pixels
  localparam int unsigned X3W     = CntW + 2;         // 3 * destination column

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegSourceWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSourceHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDestRowPix   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRotateEnable = 2'd3;

  // Register reset values
  localparam logic [DimW-1:0]  ResetWidth  = 12'd640;
  localparam logic [DimW-1:0]  ResetHeight = 12'd480;
  localparam logic [Drp3W-1:0] ResetDrp3   = 14'd1920;

  // Full-range BT.601 coefficients, Q16
  localparam int unsigned CoefW = 18;
  localparam logic signed [CoefW-1:0] CoefRv = 18'sd91881;
  localparam logic signed [CoefW-1:0] CoefGu = -18'sd22554;
  localparam logic signed [CoefW-1:0] CoefGv = -18'sd46802;
  localparam logic signed [CoefW-1:0] CoefBu = 18'sd116130;
  localparam int unsigned SumW = 28;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [OffsetW-1:0] dest_byte_offset;
    logic               frame_end;
  } pixel_out_t;

endpackage

@@ src/yuv_to_rgb_rotating_converter_core.sv @@
// Top level of the YUV 4:2:0 to RGB converter with optional clockwise rotation.
// Two register stages: input/address stage and result stage.
// Depends on yuv2rgb_pkg.
//
//  Port group   Direction  Handshake             Payload
//  in_*         input      in_valid_i/in_ready_o   pixel_in_t  (luma, chroma_blue, chroma_red)
//  out_*        output     out_valid_o/out_ready_i pixel_out_t (RGB, offset, frame_end)
//  cfg_*        input      cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One transaction per clock while the output is not stalled; stage 1 holds pixel
// and destination coordinates, stage 2 the converted colour and the byte offset
// from one multiply-add.
// Reset clears the valid flags and the counters and loads the configuration registers with their reset values.
// A stall on the output holds both stages; in_ready_o drops only when both are full.
module yuv_to_rgb_rotating_converter_core import yuv2rgb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pixel_in_t          in_pixel_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pixel_out_t         out_pixel_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_data_i
);

  // Configuration registers
  logic [DimW-1:0]  width_q, height_q;
  logic [Drp3W-1:0] drp3_q;
  logic             rotate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= ResetWidth;
      height_q <= ResetHeight;
      drp3_q   <= ResetDrp3;
      rotate_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSourceWidth:  width_q  <= cfg_data_i;
        RegSourceHeight: height_q <= cfg_data_i;
        RegDestRowPix:   drp3_q   <= {2'b00, cfg_data_i} + {1'b0, cfg_data_i, 1'b0};
        RegRotateEnable: rotate_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective dimensions: zero acts as one, oversize acts as MaxDim
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    else r = v;
    return r;
  endfunction

  // Handshake control
  logic s1_valid_q, s2_valid_q;
  logic s2_load, in_fire;

  assign s2_load    = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // Raster counters and destination coordinates
  logic [CntW-1:0] col_q, row_q;
  logic [DimW-1:0] w_eff, h_eff, h_last, row_clip;
  logic [DimW-1:0] col_next, row_next;
  logic            last_col, last_row;
  logic [CntW-1:0] out_x, out_y;
  logic [X3W-1:0]  x3;

  always_comb begin
    w_eff    = eff_dim(width_q);
    h_eff    = eff_dim(height_q);
    h_last   = h_eff - DimW'(1);
    col_next = {1'b0, col_q} + DimW'(1);
    row_next = {1'b0, row_q} + DimW'(1);
    last_col = col_next >= w_eff;
    last_row = row_next >= h_eff;
    row_clip = ({1'b0, row_q} > h_last) ? h_last : {1'b0, row_q};
    if (rotate_q) begin
      out_x = CntW'(h_last - row_clip);
      out_y = col_q;
    end else begin
      out_x = col_q;
      out_y = row_q;
    end
    x3 = {2'b00, out_x} + {1'b0, out_x, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_next[CntW-1:0];
      end else begin
        col_q <= col_next[CntW-1:0];
      end
    end
  end

  // Stage 1: pixel and destination coordinates
  pixel_in_t       s1_pix_q;
  logic [CntW-1:0] s1_oy_q;
  logic [X3W-1:0]  s1_x3_q;
  logic            s1_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= in_pixel_i;
      s1_oy_q   <= out_y;
      s1_x3_q   <= x3;
      s1_fend_q <= last_col && last_row;
    end
  end

  // Truncate a Q16 sum toward zero and clamp to 0..255
  function automatic logic [7:0] clamp_q16(input logic signed [SumW-1:0] s);
    logic [7:0] r;
    if (s[SumW-1]) r = 8'd0;
    else if (|s[SumW-2:24]) r = 8'd255;
    else r = s[23:16];
    return r;
  endfunction

  // Colour conversion and byte offset
  logic signed [8:0]      u_c, v_c;
  logic signed [SumW-1:0] base, sum_r, sum_g, sum_b;
  logic [OffsetW-1:0]     row_prod;
  pixel_out_t             res;

  always_comb begin
    u_c   = $signed({1'b0, s1_pix_q.chroma_blue}) - 9'sd128;
    v_c   = $signed({1'b0, s1_pix_q.chroma_red}) - 9'sd128;
    base  = $signed({4'b0000, s1_pix_q.luma, 16'h0000});
    sum_r = base + SumW'(CoefRv * v_c);
    sum_g = base + SumW'(CoefGu * u_c) + SumW'(CoefGv * v_c);
    sum_b = base + SumW'(CoefBu * u_c);
    row_prod = OffsetW'(s1_oy_q * drp3_q);
    res.red   = clamp_q16(sum_r);
    res.green = clamp_q16(sum_g);
    res.blue  = clamp_q16(sum_b);
    res.dest_byte_offset = row_prod + OffsetW'(s1_x3_q);
    res.frame_end = s1_fend_q;
  end

  // Stage 2: result register
  pixel_out_t s2_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_load) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_valid_q) begin
      s2_pix_q <= res;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_pixel_o = s2_pix_q;

  // Checks
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_col && last_row |=> col_q == '0 && row_q == '0)
    else $error("counters did not wrap at end of frame");

  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !last_col |=> row_q == $past(row_q))
    else $error("row advanced before last column");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while both stages are stalled");

  a_s1_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_load |=> s1_valid_q && $stable(s1_oy_q) && $stable(s1_x3_q))
    else $error("stage 1 contents lost during stall");

endmodule
